>>> hw/rtl/fsr_pkg.sv
`timescale 1ns / 1ps

package fsr_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int REPLACE_MAX = 16;
    // One cell per window slot; the row also holds the replacement burst.
    localparam int NCELL = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
    localparam int IDX_W = $clog2(NCELL);
    localparam int LEN_W = IDX_W + 1;
    localparam int CHAR_W = 8;
    localparam int POS_W = 4;
    localparam int CFG_W = 5;

    // Item kinds
    localparam logic [1:0] KIND_TEXT = 2'd0;
    localparam logic [1:0] KIND_PAT  = 2'd1;
    localparam logic [1:0] KIND_REP  = 2'd2;

    // Register indexes
    localparam logic REG_PATTERN_LENGTH = 1'b0;
    localparam logic REG_REPLACE_LENGTH = 1'b1;

    // Cell window operations
    localparam logic [2:0] CELL_HOLD     = 3'd0;
    localparam logic [2:0] CELL_WRITE    = 3'd1;
    localparam logic [2:0] CELL_SHIFT_IN = 3'd2;
    localparam logic [2:0] CELL_LOAD_REP = 3'd3;
    localparam logic [2:0] CELL_DRAIN    = 3'd4;

    typedef struct packed {
        logic [1:0]        kind;
        logic [POS_W-1:0]  position;
        logic [CHAR_W-1:0] char_in;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              char_valid;
        logic              end_of_string;
        logic              found;
    } result_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  wlen;
        logic [CHAR_W-1:0] ch;
        logic              load_pat;
        logic              load_rep;
        logic [POS_W-1:0]  position;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/fsr_cell.sv
`timescale 1ns / 1ps

module fsr_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [fsr_pkg::IDX_W-1:0]   cell_idx,
    input  fsr_pkg::cell_ctrl_t         ctrl,
    input  logic [fsr_pkg::CHAR_W-1:0]  neighbor,
    output logic [fsr_pkg::CHAR_W-1:0]  win,
    output logic                        match
);

    logic [fsr_pkg::CHAR_W-1:0] win_reg;
    logic [fsr_pkg::CHAR_W-1:0] win_next;
    logic [fsr_pkg::CHAR_W-1:0] pat_reg;
    logic [fsr_pkg::CHAR_W-1:0] rep_reg;

    always_comb
    begin
        win_next = win_reg;
        unique case (ctrl.op)
            fsr_pkg::CELL_HOLD:     win_next = win_reg;
            fsr_pkg::CELL_WRITE:    win_next = (cell_idx == ctrl.idx) ? ctrl.ch : win_reg;
            fsr_pkg::CELL_SHIFT_IN: win_next = (cell_idx == ctrl.idx) ? ctrl.ch : neighbor;
            fsr_pkg::CELL_LOAD_REP: win_next = rep_reg;
            fsr_pkg::CELL_DRAIN:    win_next = neighbor;
            default:                win_next = win_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else
            win_reg <= win_next;
    end

    // Store bytes are undefined until loaded.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_pat && ctrl.position == fsr_pkg::POS_W'(cell_idx))
            pat_reg <= ctrl.ch;
        if (ctrl.load_rep && ctrl.position == fsr_pkg::POS_W'(cell_idx))
            rep_reg <= ctrl.ch;
    end

    // Slots below wlen hold the window; slot wlen sees the incoming character.
    always_comb
    begin
        if (cell_idx < ctrl.wlen)
            match = (win_reg == pat_reg);
        else if (cell_idx == ctrl.wlen)
            match = (ctrl.ch == pat_reg);
        else
            match = 1'b1;
    end

    assign win = win_reg;

endmodule

>>> hw/rtl/first_substring_replace.sv
`timescale 1ns / 1ps

// Streaming find-and-replace of the first occurrence of a stored pattern.
// Load pattern and replacement characters by position (kind 1 and 2) and set
// pattern_length / replace_length while idle, then stream text (kind 0).
// Text leaves delayed by pattern_length-1 characters; the first match is
// replaced and later text passes through. The final result of each string
// carries end_of_string and found; a string that ends without a character to
// show ends on a marker result with char_valid low. Rate: one item per cycle
// while the output is not stalled. A match, or the last character of a
// string, starts a burst of N results (N up to 16: the replacement, or the
// window flush) that shifts out of the cell row one per cycle while the output
// is not stalled; the input is stalled until the burst is out. Any result
// waits in the output register while the next item is taken.
module first_substring_replace (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [fsr_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  fsr_pkg::item_t                 item,
    output logic                           result_valid,
    input  logic                           result_stall,
    output fsr_pkg::result_t               result
);

    // Config registers
    logic [fsr_pkg::CFG_W-1:0] plen_reg;
    logic [fsr_pkg::CFG_W-1:0] rlen_reg;

    // Control state
    logic [fsr_pkg::IDX_W-1:0] fill_reg, fill_next;
    logic                      matched_reg, matched_next;
    logic [fsr_pkg::LEN_W-1:0] drain_cnt_reg, drain_cnt_next;
    logic                      drain_end_reg, drain_end_next;
    logic                      drain_found_reg, drain_found_next;
    logic                      marker_reg, marker_next;

    // Output register
    logic                      result_valid_reg;
    fsr_pkg::result_t          result_reg;

    logic                      busy;
    logic                      can_load;
    logic                      item_acc;
    logic                      emit_valid;
    fsr_pkg::result_t          emit_data;

    logic [fsr_pkg::LEN_W-1:0] plen_eff;
    logic [fsr_pkg::LEN_W-1:0] rlen_eff;
    logic [fsr_pkg::IDX_W-1:0] wlen;
    logic                      full;
    logic                      hit;

    fsr_pkg::cell_ctrl_t         ctrl;
    logic [fsr_pkg::CHAR_W-1:0]  win_q [fsr_pkg::NCELL];
    logic [fsr_pkg::CHAR_W-1:0]  nb_q  [fsr_pkg::NCELL];
    logic [fsr_pkg::NCELL-1:0]   match_vec;

    // Effective lengths: a pattern length of 0 acts as 1; oversize values clip to the store depth.
    always_comb
    begin
        if (plen_reg == '0)
            plen_eff = fsr_pkg::LEN_W'(1);
        else if (plen_reg > fsr_pkg::CFG_W'(fsr_pkg::PATTERN_MAX))
            plen_eff = fsr_pkg::LEN_W'(fsr_pkg::PATTERN_MAX);
        else
            plen_eff = fsr_pkg::LEN_W'(plen_reg);

        if (rlen_reg > fsr_pkg::CFG_W'(fsr_pkg::REPLACE_MAX))
            rlen_eff = fsr_pkg::LEN_W'(fsr_pkg::REPLACE_MAX);
        else
            rlen_eff = fsr_pkg::LEN_W'(rlen_reg);
    end

    assign wlen = fsr_pkg::IDX_W'(plen_eff - fsr_pkg::LEN_W'(1));
    assign full = (fill_reg == wlen);
    assign hit  = full && (&match_vec);

    assign busy       = (drain_cnt_reg != '0) || marker_reg;
    assign can_load   = !result_valid_reg || !result_stall;
    assign item_stall = busy || !can_load;
    assign item_acc   = item_valid && !item_stall;

    // Cell row: each cell hands its window byte to its lower neighbor.
    genvar g;
    generate
        for (g = 0; g < fsr_pkg::NCELL; g++)
        begin : g_cell
            if (g == fsr_pkg::NCELL - 1)
            begin : g_end
                assign nb_q[g] = '0;
            end
            else
            begin : g_mid
                assign nb_q[g] = win_q[g+1];
            end

            fsr_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (fsr_pkg::IDX_W'(g)),
                .ctrl     (ctrl),
                .neighbor (nb_q[g]),
                .win      (win_q[g]),
                .match    (match_vec[g])
            );
        end
    endgenerate

    always_comb
    begin
        ctrl.op       = fsr_pkg::CELL_HOLD;
        ctrl.idx      = fill_reg;
        ctrl.wlen     = wlen;
        ctrl.ch       = item.char_in;
        ctrl.load_pat = 1'b0;
        ctrl.load_rep = 1'b0;
        ctrl.position = item.position;

        emit_valid = 1'b0;
        emit_data  = '0;

        fill_next        = fill_reg;
        matched_next     = matched_reg;
        drain_cnt_next   = drain_cnt_reg;
        drain_end_next   = drain_end_reg;
        drain_found_next = drain_found_reg;
        marker_next      = marker_reg;

        if (busy)
        begin
            if (can_load)
            begin
                emit_valid = 1'b1;
                if (drain_cnt_reg != '0)
                begin
                    // burst transfer out of cell 0
                    ctrl.op                 = fsr_pkg::CELL_DRAIN;
                    emit_data.char_out      = win_q[0];
                    emit_data.char_valid    = 1'b1;
                    emit_data.end_of_string = drain_end_reg &&
                                              (drain_cnt_reg == fsr_pkg::LEN_W'(1));
                    emit_data.found         = emit_data.end_of_string && drain_found_reg;
                    drain_cnt_next          = drain_cnt_reg - fsr_pkg::LEN_W'(1);
                end
                else
                begin
                    // empty end: marker result only
                    emit_data.end_of_string = 1'b1;
                    emit_data.found         = drain_found_reg;
                    marker_next             = 1'b0;
                end
            end
        end
        else if (item_acc)
        begin
            case (item.kind)
                fsr_pkg::KIND_PAT: ctrl.load_pat = 1'b1;
                fsr_pkg::KIND_REP: ctrl.load_rep = 1'b1;
                fsr_pkg::KIND_TEXT:
                begin
                    if (matched_reg)
                    begin
                        if (item.last)
                        begin
                            ctrl.op          = fsr_pkg::CELL_WRITE;
                            drain_cnt_next   = {1'b0, fill_reg} + fsr_pkg::LEN_W'(1);
                            drain_end_next   = 1'b1;
                            drain_found_next = 1'b1;
                        end
                        else
                        begin
                            emit_valid           = 1'b1;
                            emit_data.char_out   = item.char_in;
                            emit_data.char_valid = 1'b1;
                        end
                    end
                    else if (hit)
                    begin
                        // window dropped; replacement takes its place in the row
                        ctrl.op          = fsr_pkg::CELL_LOAD_REP;
                        fill_next        = '0;
                        matched_next     = 1'b1;
                        drain_cnt_next   = rlen_eff;
                        drain_end_next   = item.last;
                        drain_found_next = 1'b1;
                        marker_next      = item.last && (rlen_eff == '0);
                    end
                    else if (item.last)
                    begin
                        // flush window plus this character
                        ctrl.op          = fsr_pkg::CELL_WRITE;
                        drain_cnt_next   = {1'b0, fill_reg} + fsr_pkg::LEN_W'(1);
                        drain_end_next   = 1'b1;
                        drain_found_next = 1'b0;
                    end
                    else if (full)
                    begin
                        emit_valid           = 1'b1;
                        emit_data.char_valid = 1'b1;
                        if (wlen == '0)
                            emit_data.char_out = item.char_in;
                        else
                        begin
                            emit_data.char_out = win_q[0];
                            ctrl.op            = fsr_pkg::CELL_SHIFT_IN;
                            ctrl.idx           = wlen - fsr_pkg::IDX_W'(1);
                        end
                    end
                    else
                    begin
                        ctrl.op   = fsr_pkg::CELL_WRITE;
                        fill_next = fill_reg + fsr_pkg::IDX_W'(1);
                    end

                    if (item.last)
                    begin
                        fill_next    = '0;
                        matched_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg         <= fsr_pkg::CFG_W'(1);
            rlen_reg         <= '0;
            fill_reg         <= '0;
            matched_reg      <= 1'b0;
            drain_cnt_reg    <= '0;
            drain_end_reg    <= 1'b0;
            drain_found_reg  <= 1'b0;
            marker_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg        <= fill_next;
            matched_reg     <= matched_next;
            drain_cnt_reg   <= drain_cnt_next;
            drain_end_reg   <= drain_end_next;
            drain_found_reg <= drain_found_next;
            marker_reg      <= marker_next;
            if (can_load)
                result_valid_reg <= emit_valid;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    fsr_pkg::REG_PATTERN_LENGTH:
                        if (fill_reg == '0)
                            plen_reg <= cfg_data;
                    fsr_pkg::REG_REPLACE_LENGTH:
                        rlen_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load)
            result_reg <= emit_data;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= wlen)
        else $error("window fill beyond pattern window");

    a_matched_empty: assert property (@(posedge clk) disable iff (!rst_n)
        matched_reg |-> (fill_reg == '0))
        else $error("window not empty after match");

    a_burst_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> item_stall)
        else $error("item taken during result burst");

    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        drain_cnt_reg <= fsr_pkg::LEN_W'(fsr_pkg::NCELL))
        else $error("burst longer than cell row");

    a_found_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.found) |-> result.end_of_string)
        else $error("found outside end of string");
`endif

endmodule
